@@ hdl/lfa_pkg.sv @@
// Shared types and constants for the lowest free id allocator.
// Used by the summary, the bitmap control and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lfa_pkg;

  // bitmap word geometry: one memory word holds the free bits of 32 ids
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // request kinds
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_EMPTY        = 2'd1;
  localparam logic [1:0] STATUS_ALREADY_FREE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_MODIFY,
    ST_RESP
  } lfa_state_t;

  // summary update from the bitmap write-back
  typedef struct packed {
    logic wr;
    logic has_free;
  } sum_upd_t;

endpackage

`default_nettype wire

@@ hdl/lfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data only changes on a read enable. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/lfa_lowest.sv @@
// Priority encoder: index of the lowest set bit of a vector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfa_lowest #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0]                           vec,
  output logic      [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx,
  output logic                                            found
);

  localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // scan from the top so the lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    found = |vec;
  end

endmodule

`default_nettype wire

@@ hdl/lfa_summary.sv @@
// Two-level free summary over the bitmap words: one bit per word, one per group of 32 words.
// Finds the lowest word with a free id. Depends on lfa_pkg and lfa_lowest.
`timescale 1ns / 1ps
`default_nettype none

module lfa_summary #(
  parameter int NUM_WORDS = 8
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire lfa_pkg::sum_upd_t                              upd,
  input  wire logic [(NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1)-1:0] upd_word,
  output logic      [(NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1)-1:0] low_word,
  output logic                                                empty
);

  import lfa_pkg::*;

  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int NUM_GROUPS = (NUM_WORDS + WORD_W - 1) / WORD_W;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int EXT_W      = GRP_W + BIT_W;

  logic [NUM_GROUPS-1:0][WORD_W-1:0] lvl1;
  logic [NUM_GROUPS-1:0]             lvl2;

  logic [GRP_W-1:0] grp_idx;
  logic             grp_found;
  logic [BIT_W-1:0] in_grp_idx;
  logic             in_grp_found;
  logic [EXT_W-1:0] low_ext;

  logic [EXT_W-1:0]  upd_ext;
  logic [GRP_W-1:0]  upd_grp;
  logic [BIT_W-1:0]  upd_bit;
  logic [WORD_W-1:0] upd_row;

  // lowest group with a free word, then lowest word in it
  lfa_lowest #(.WIDTH(NUM_GROUPS)) u_grp_enc (
    .vec   (lvl2),
    .idx   (grp_idx),
    .found (grp_found)
  );

  lfa_lowest #(.WIDTH(WORD_W)) u_word_enc (
    .vec   (lvl1[grp_idx]),
    .idx   (in_grp_idx),
    .found (in_grp_found)
  );

  assign low_ext  = {grp_idx, in_grp_idx};
  assign low_word = low_ext[WORD_AW-1:0];
  assign empty    = !(grp_found && in_grp_found);

  // row of the updated group with the new word bit folded in
  assign upd_ext = EXT_W'(upd_word);
  assign upd_grp = upd_ext[EXT_W-1:BIT_W];
  assign upd_bit = upd_ext[BIT_W-1:0];

  always_comb begin
    upd_row          = lvl1[upd_grp];
    upd_row[upd_bit] = upd.has_free;
  end

  // summary flops; every existing word starts with free ids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        for (int b = 0; b < WORD_W; b++) begin
          lvl1[g][b] <= (g * WORD_W + b) < NUM_WORDS;
        end
        lvl2[g] <= 1'b1;
      end
    end else if (upd.wr) begin
      lvl1[upd_grp] <= upd_row;
      lvl2[upd_grp] <= |upd_row;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lowest_free_id_allocator.sv @@
// Lowest-first id pool. An allocate request returns the lowest free id and marks it in use;
// a release request returns an id to the pool. The request kind travels on s_tuser.
// Free bits live in a RAM of 32-bit words, with a two-level summary in flops that points at
// the lowest word holding a free id. An allocate or an in-range release goes through
// accept, summary search, RAM read, and modify and write back, one request at a time;
// its result is valid in the cycle after the modify, when the next request can already
// be accepted. An allocate from an empty pool or a release of an id beyond the pool skips
// the RAM and goes from the search straight to the result. A result that is not taken
// holds the next request in its last step until the result register frees. After reset a
// clearing pass writes every bitmap word, during which no request is accepted.
// Allocate from an empty pool gives status 1; releasing an id that is already free or
// outside the pool gives status 2.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_id_allocator #(
  parameter int NUM_IDS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // release_id [7:0]
  input  wire logic        s_tuser,   // mode [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // granted_id [7:0], status [9:8], zero [15:10]
);

  import lfa_pkg::*;

  localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FULL_W    = WORD_AW + BIT_W;
  localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_W:0]   LAST_ONE  = (WORD_W + 1)'(1) << LAST_BITS;
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'(LAST_ONE - 1'b1);
  localparam logic [16:0]       NUM_IDS_V = 17'(NUM_IDS);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

  lfa_state_t state, state_next;

  // request registers
  logic              mode_q;
  logic [7:0]        rid_q;
  logic [WORD_AW-1:0] word_idx;
  logic [1:0]        status_q;
  logic [WORD_AW-1:0] clr_cnt;

  // summary
  sum_upd_t          sum_upd;
  logic [WORD_AW-1:0] low_word;
  logic              pool_empty;

  // ram
  logic              ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;

  // modify stage
  logic [BIT_W-1:0]  low_bit;
  logic              low_found;
  logic [BIT_W-1:0]  bit_sel;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] new_word;
  logic              already_free;
  logic [FULL_W-1:0] full_id;
  logic [FULL_W+7:0] full_id_ext;
  logic [7:0]        granted;
  logic [1:0]        mod_status;

  // release id checks
  logic [WORD_AW+7:0] rid_ext;
  logic               rid_out_of_range;

  logic out_free;
  logic in_accept;
  logic finish;

  assign out_free  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  lfa_summary #(.NUM_WORDS(NUM_WORDS)) u_summary (
    .clk      (clk),
    .rst      (rst),
    .upd      (sum_upd),
    .upd_word (word_idx),
    .low_word (low_word),
    .empty    (pool_empty)
  );

  lfa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (word_idx),
    .rdata (ram_rdata)
  );

  lfa_lowest #(.WIDTH(WORD_W)) u_bit_enc (
    .vec   (ram_rdata),
    .idx   (low_bit),
    .found (low_found)
  );

  // release id decode
  assign rid_ext          = (WORD_AW + 8)'(rid_q);
  assign rid_out_of_range = {9'b0, rid_q} >= NUM_IDS_V;

  // bit update on the word read back
  always_comb begin
    bit_sel      = (mode_q == MODE_ALLOC) ? low_bit : rid_q[BIT_W-1:0];
    bit_mask     = WORD_W'(1) << bit_sel;
    already_free = (mode_q == MODE_RELEASE) && ((ram_rdata & bit_mask) != '0);
    if (mode_q == MODE_ALLOC) begin
      new_word = ram_rdata & ~bit_mask;
    end else begin
      new_word = ram_rdata | bit_mask;
    end
    full_id     = {word_idx, bit_sel};
    full_id_ext = {8'b0, full_id};
    if (mode_q == MODE_ALLOC && low_found) begin
      granted = full_id_ext[7:0];
    end else begin
      granted = 8'd0;
    end
    mod_status = already_free ? STATUS_ALREADY_FREE : STATUS_OK;
  end

  assign finish = (state == ST_MODIFY) && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_WORD) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (mode_q == MODE_ALLOC) begin
          state_next = pool_empty ? ST_RESP : ST_READ;
        end else begin
          state_next = rid_out_of_range ? ST_RESP : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready         = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = word_idx;
    ram_wdata        = new_word;
    sum_upd.wr       = 1'b0;
    sum_upd.has_free = |new_word;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = (clr_cnt == LAST_WORD) ? LAST_MASK : '1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_MODIFY: begin
        ram_we     = finish && !already_free;
        sum_upd.wr = finish && !already_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if ((state == ST_MODIFY || state == ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request payload and result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= s_tuser;
      rid_q  <= s_tdata;
    end
    if (state == ST_SEARCH) begin
      if (mode_q == MODE_ALLOC) begin
        word_idx <= low_word;
        status_q <= STATUS_EMPTY;
      end else begin
        word_idx <= rid_ext[WORD_AW+BIT_W-1:BIT_W];
        status_q <= STATUS_ALREADY_FREE;
      end
    end
    if (finish) begin
      m_tdata <= {6'b0, mod_status, granted};
    end else if (state == ST_RESP && out_free) begin
      m_tdata <= {6'b0, status_q, 8'd0};
    end
  end

endmodule

`default_nettype wire
